// File: src/rcva_pkg.sv
// Shared types and constants for the radial cylindric vector alignment block.
package rcva_pkg;

  localparam int WORD_W    = 48;
  localparam int AXIS_IN_W = 34;
  localparam int D_W       = WORD_W + 2;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam int LAT_NORM  = 3;
  localparam int LAT_CROSS = 2;

  localparam logic [15:0] SIN_TOL = 16'd60740;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_AXIS_X   = 3'd3;
  localparam logic [2:0] REG_AXIS_Y   = 3'd4;
  localparam logic [2:0] REG_AXIS_Z   = 3'd5;

  typedef enum logic [1:0] {
    ST_PROJ = 2'd0,
    ST_PASS = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
    logic signed [WORD_W-1:0] point_z;
    logic signed [WORD_W-1:0] vec_x;
    logic signed [WORD_W-1:0] vec_y;
    logic signed [WORD_W-1:0] vec_z;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] out_x;
    logic signed [WORD_W-1:0] out_y;
    logic signed [WORD_W-1:0] out_z;
    status_t                  status;
  } result_t;

endpackage

// File: src/radial_cylindric_vector_align.sv
// Radial cylindric vector alignment: top level with register port and pipeline.
//
// One beat is accepted in every clock cycle; busy never rises. The result
// appears on result, marked by done for one cycle. The pipeline depth is set
// by the chains of square roots and the divider, which resolve one bit per
// pipeline stage. Results leave in the order beats came in and cannot be
// held off. The user must write configuration through the register port
// only while no beat is in flight; the block itself does not enforce this.
module radial_cylindric_vector_align
  import rcva_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  item_t             item,
  output logic              done,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int AXIS_W = (FRAC_BITS + 2 > AXIS_IN_W) ? FRAC_BITS + 2 : AXIS_IN_W;
  localparam int SW_W   = $clog2(WORD_W);
  localparam int E_W    = $clog2(2 * 31);

  localparam int S_DN   = LAT_NORM;
  localparam int S_CR   = S_DN + LAT_CROSS;
  localparam int S_CS   = S_CR + LAT_NORM;
  localparam int S_NA   = S_DN + 2 + 31;
  localparam int S_NC   = S_CS + 2 + 31;
  localparam int S_THR  = S_NA + 2;
  localparam int S_THRE = S_THR + 1;
  localparam int S_M    = S_CR + LAT_NORM;
  localparam int S_BP   = S_M + LAT_CROSS;
  localparam int S_BN   = S_BP + LAT_NORM;
  localparam int S_T    = S_BN + LAT_CROSS;
  localparam int S_TT   = S_T + LAT_NORM;
  localparam int S_TN   = S_TT + 2 + 31;
  localparam int S_RV   = LAT_NORM + 2 + 32;
  localparam int S_PR   = S_RV + 1;
  localparam int S_Q    = S_TN + 32;

  localparam logic [WORD_W-1:0] MAX_MAG = {1'b0, {(WORD_W-1){1'b1}}};

  logic signed [WORD_W-1:0] center [3];
  logic signed [AXIS_W-1:0] axis [3];
  logic [2:0]               reg_idx;
  logic                     wr;

  logic                     acc;
  logic [S_Q:0]             vld;
  logic signed [WORD_W-1:0] p_in [3];
  logic signed [WORD_W-1:0] v_in [3];
  logic signed [D_W-1:0]    d0 [3];
  logic signed [WORD_W-1:0] v0 [3];
  logic                     dz0;

  logic signed [30:0] an [3];
  logic signed [30:0] dn [3];
  logic [30:0]        na;
  logic [30:0]        nd;
  logic signed [61:0] cr [3];
  logic signed [30:0] cs [3];
  logic [E_W-1:0]     e8;
  logic [E_W-1:0]     e38;
  logic [30:0]        nc;
  logic [61:0]        prod_ad;
  logic [61:0]        thr_full;
  logic [45:0]        thr;
  logic [45:0]        thre;
  logic [45:0]        thre41;
  logic               nanz41;
  logic               align83;

  logic signed [20:0] m8 [3];
  logic signed [20:0] m13 [3];
  logic signed [20:0] vn3 [3];
  logic signed [20:0] vn8 [3];
  logic signed [41:0] bp [3];
  logic signed [20:0] bn [3];
  logic signed [41:0] tv [3];
  logic signed [30:0] tt [3];
  logic signed [30:0] tt37 [3];
  logic [30:0]        tn;
  logic               tz83;

  logic signed [31:0] vs [3];
  logic [SW_W-1:0]    s3;
  logic [SW_W-1:0]    s83;
  logic [31:0]        rv;
  logic [29:0]        ttm [3];
  logic [61:0]        prod38 [3];
  logic [61:0]        prod51 [3];
  logic [31:0]        quo [3];
  logic [2:0]         sgn18;
  logic [2:0]         sgn83;
  logic               dz83;
  logic [WORD_W-1:0]  v83 [3];
  logic [WORD_W-1:0]  qsat [3];
  logic [WORD_W-1:0]  proj [3];

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign acc     = start & ~busy;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        center[i] <= '0;
        axis[i]   <= '0;
      end
      axis[0] <= {{(AXIS_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    end else if (wr) begin
      case (reg_idx)
        REG_CENTER_X: center[0] <= pwdata[WORD_W-1:0];
        REG_CENTER_Y: center[1] <= pwdata[WORD_W-1:0];
        REG_CENTER_Z: center[2] <= pwdata[WORD_W-1:0];
        REG_AXIS_X:   axis[0] <= AXIS_W'($signed(pwdata[AXIS_IN_W-1:0]));
        REG_AXIS_Y:   axis[1] <= AXIS_W'($signed(pwdata[AXIS_IN_W-1:0]));
        REG_AXIS_Z:   axis[2] <= AXIS_W'($signed(pwdata[AXIS_IN_W-1:0]));
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_X: prdata = DATA_W'(center[0]);
      REG_CENTER_Y: prdata = DATA_W'(center[1]);
      REG_CENTER_Z: prdata = DATA_W'(center[2]);
      REG_AXIS_X:   prdata = DATA_W'(axis[0]);
      REG_AXIS_Y:   prdata = DATA_W'(axis[1]);
      REG_AXIS_Z:   prdata = DATA_W'(axis[2]);
      default:      prdata = '0;
    endcase
  end

  // entry: offset from q = centre + axis
  assign p_in[0] = item.point_x;
  assign p_in[1] = item.point_y;
  assign p_in[2] = item.point_z;
  assign v_in[0] = item.vec_x;
  assign v_in[1] = item.vec_y;
  assign v_in[2] = item.vec_z;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d0[i] <= D_W'(p_in[i]) - D_W'(center[i]) - D_W'(axis[i]);
      v0[i] <= v_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[S_Q-1:0], acc};
    end
  end

  assign dz0 = (d0[0] == '0) && (d0[1] == '0) && (d0[2] == '0);

  // alignment test
  rcva_norm3 #(.IN_W(AXIS_W), .BITS(30), .GROW(1'b1)) u_norm_a (
    .clk, .x(axis), .y(an), .sh()
  );
  rcva_norm3 #(.IN_W(D_W), .BITS(30), .GROW(1'b1)) u_norm_d (
    .clk, .x(d0), .y(dn), .sh()
  );
  rcva_len #(.CW(31)) u_len_a (.clk, .c(an), .root(na));
  rcva_len #(.CW(31)) u_len_d (.clk, .c(dn), .root(nd));
  rcva_cross #(.IN_W(31)) u_cross_ad (.clk, .a(an), .b(dn), .r(cr));
  rcva_norm3 #(.IN_W(62), .BITS(30), .GROW(1'b0)) u_norm_c (
    .clk, .x(cr), .y(cs), .sh(e8)
  );
  rcva_len #(.CW(31)) u_len_c (.clk, .c(cs), .root(nc));

  assign thr_full = prod_ad[61:16] * SIN_TOL;

  always_ff @(posedge clk) begin
    prod_ad <= na * nd;
    thr     <= thr_full[61:16];
    thre    <= thr >> e38;
  end

  rcva_delay #(.W(E_W), .DEPTH(S_THR - S_CS)) u_dly_e (.clk, .d(e8), .q(e38));
  rcva_delay #(.W(46), .DEPTH(S_NC - S_THRE)) u_dly_thre (.clk, .d(thre), .q(thre41));
  rcva_delay #(.W(1), .DEPTH(S_NC - S_NA)) u_dly_nanz (
    .clk, .d(na != '0), .q(nanz41)
  );
  rcva_delay #(.W(1), .DEPTH(S_Q - S_NC)) u_dly_align (
    .clk, .d(nanz41 && (46'(nc) <= thre41)), .q(align83)
  );

  // tangent direction, sign of n folded into the second cross product
  rcva_norm3 #(.IN_W(62), .BITS(20), .GROW(1'b1)) u_norm_n (
    .clk, .x(cr), .y(m8), .sh()
  );
  rcva_norm3 #(.IN_W(WORD_W), .BITS(20), .GROW(1'b1)) u_norm_v (
    .clk, .x(v0), .y(vn3), .sh()
  );
  rcva_cross #(.IN_W(21)) u_cross_b (.clk, .a(m8), .b(vn8), .r(bp));
  rcva_norm3 #(.IN_W(42), .BITS(20), .GROW(1'b1)) u_norm_b (
    .clk, .x(bp), .y(bn), .sh()
  );
  rcva_cross #(.IN_W(21)) u_cross_t (.clk, .a(bn), .b(m13), .r(tv));
  rcva_norm3 #(.IN_W(42), .BITS(30), .GROW(1'b1)) u_norm_t (
    .clk, .x(tv), .y(tt), .sh()
  );
  rcva_len #(.CW(31)) u_len_t (.clk, .c(tt), .root(tn));

  // magnitude of v
  rcva_norm3 #(.IN_W(WORD_W), .BITS(31), .GROW(1'b0)) u_norm_s (
    .clk, .x(v0), .y(vs), .sh(s3)
  );
  rcva_len #(.CW(32)) u_len_v (.clk, .c(vs), .root(rv));

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rcva_delay #(.W(21), .DEPTH(S_M - S_DN)) u_dly_vn (.clk, .d(vn3[i]), .q(vn8[i]));
    rcva_delay #(.W(21), .DEPTH(S_BN - S_M)) u_dly_m (.clk, .d(m8[i]), .q(m13[i]));
    rcva_delay #(.W(31), .DEPTH(S_RV - S_TT)) u_dly_tt (.clk, .d(tt[i]), .q(tt37[i]));
    rcva_delay #(.W(62), .DEPTH(S_TN - S_PR)) u_dly_pr (
      .clk, .d(prod38[i]), .q(prod51[i])
    );
    rcva_delay #(.W(WORD_W), .DEPTH(S_Q)) u_dly_v (.clk, .d(v0[i]), .q(v83[i]));
    rcva_div #(.NUM_W(62), .DEN_W(31), .Q_W(32)) u_div (
      .clk, .num(prod51[i]), .den(tn), .quo(quo[i])
    );

    assign ttm[i]   = tt37[i][30] ? 30'(-tt37[i]) : 30'(tt37[i]);
    assign sgn18[i] = tt[i][30];

    always_ff @(posedge clk) begin
      prod38[i] <= 62'(ttm[i]) * 62'(rv);
    end

    always_comb begin
      qsat[i] = (WORD_W'(quo[i]) > (MAX_MAG >> s83)) ? MAX_MAG : (WORD_W'(quo[i]) << s83);
      proj[i] = sgn83[i] ? -qsat[i] : qsat[i];
    end
  end

  rcva_delay #(.W(3), .DEPTH(S_Q - S_TT)) u_dly_sgn (.clk, .d(sgn18), .q(sgn83));
  rcva_delay #(.W(1), .DEPTH(S_Q - S_TN)) u_dly_tz (.clk, .d(tn == '0), .q(tz83));
  rcva_delay #(.W(SW_W), .DEPTH(S_Q - LAT_NORM)) u_dly_s (.clk, .d(s3), .q(s83));
  rcva_delay #(.W(1), .DEPTH(S_Q)) u_dly_dz (.clk, .d(dz0), .q(dz83));

  // output beat
  always_ff @(posedge clk) begin
    if (dz83 || align83) begin
      result.out_x  <= v83[0];
      result.out_y  <= v83[1];
      result.out_z  <= v83[2];
      result.status <= ST_PASS;
    end else if (tz83) begin
      result.out_x  <= '0;
      result.out_y  <= '0;
      result.out_z  <= '0;
      result.status <= ST_ZERO;
    end else begin
      result.out_x  <= proj[0];
      result.out_y  <= proj[1];
      result.out_z  <= proj[2];
      result.status <= ST_PROJ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[S_Q];
    end
  end

endmodule

// File: src/rcva_delay.sv
// Fixed-length delay line for payload travelling beside the pipeline.
module rcva_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// File: src/rcva_norm3.sv
// Three-stage power-of-two normaliser for a signed 3-vector.
module rcva_norm3 #(
  parameter int IN_W = 50,
  parameter int BITS = 30,
  parameter bit GROW = 1'b1
) (
  input  logic                      clk,
  input  logic signed [IN_W-1:0]    x [3],
  output logic signed [BITS:0]      y [3],
  output logic [$clog2(IN_W)-1:0]   sh
);

  localparam int SH_W = $clog2(IN_W);
  localparam int UP_W = $clog2(BITS);
  localparam int XW   = IN_W + BITS;

  logic [IN_W-1:0] mag_c [3];
  logic [IN_W-1:0] max_c;
  logic [IN_W-1:0] mag1 [3];
  logic [2:0]      neg1;
  logic [IN_W-1:0] max1;

  logic [SH_W-1:0] lead;
  logic [SH_W-1:0] rsh_c;
  logic [UP_W-1:0] lsh_c;
  logic [IN_W-1:0] mag2 [3];
  logic [2:0]      neg2;
  logic [SH_W-1:0] rsh2;
  logic [UP_W-1:0] lsh2;

  logic [XW-1:0]        ext [3];
  logic [XW-1:0]        sv [3];
  logic signed [BITS:0] y_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = x[i][IN_W-1] ? IN_W'(-x[i]) : IN_W'(x[i]);
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) max_c = mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] <= mag_c[i];
      neg1[i] <= x[i][IN_W-1];
    end
    max1 <= max_c;
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (max1[i]) lead = SH_W'(i);
    end
    rsh_c = '0;
    lsh_c = '0;
    if (int'(lead) >= BITS) begin
      rsh_c = SH_W'(int'(lead) - BITS + 1);
    end else if (GROW && (max1 != '0) && (int'(lead) < BITS - 1)) begin
      lsh_c = UP_W'(BITS - 1 - int'(lead));
    end
  end

  always_ff @(posedge clk) begin
    mag2 <= mag1;
    neg2 <= neg1;
    rsh2 <= rsh_c;
    lsh2 <= lsh_c;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = XW'(mag2[i]);
      sv[i]  = (ext[i] << lsh2) >> rsh2;
      y_c[i] = neg2[i] ? -$signed({1'b0, sv[i][BITS-1:0]}) : $signed({1'b0, sv[i][BITS-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    y  <= y_c;
    sh <= rsh2;
  end

endmodule

// File: src/rcva_cross.sv
// Two-stage exact cross product of signed 3-vectors.
module rcva_cross #(
  parameter int IN_W = 31
) (
  input  logic                       clk,
  input  logic signed [IN_W-1:0]     a [3],
  input  logic signed [IN_W-1:0]     b [3],
  output logic signed [2*IN_W-1:0]   r [3]
);

  logic signed [2*IN_W-1:0] p [6];

  always_ff @(posedge clk) begin
    p[0] <= a[1] * b[2];
    p[1] <= a[2] * b[1];
    p[2] <= a[2] * b[0];
    p[3] <= a[0] * b[2];
    p[4] <= a[0] * b[1];
    p[5] <= a[1] * b[0];
    r[0] <= p[0] - p[1];
    r[1] <= p[2] - p[3];
    r[2] <= p[4] - p[5];
  end

endmodule

// File: src/rcva_len.sv
// Pipelined vector length: squares, sum, then one root bit per stage.
module rcva_len #(
  parameter int CW = 31
) (
  input  logic                  clk,
  input  logic signed [CW-1:0]  c [3],
  output logic [CW-1:0]         root
);

  localparam int N  = CW;
  localparam int SW = 2 * CW;
  localparam int RW = N + 2;

  logic signed [SW-1:0] sqf [3];
  logic [SW-3:0]        sq [3];
  logic [SW-1:0]        sum;

  logic [RW-1:0] rs [N];
  logic [N-1:0]  qs [N];
  logic [SW-1:0] xs [N];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqf[i] = c[i] * c[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= sqf[i][SW-3:0];
    end
    sum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW-1:0] r_in;
    logic [N-1:0]  q_in;
    logic [SW-1:0] x_in;
    logic [RW+1:0] t;
    logic [RW+1:0] sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign x_in = sum;
    end else begin : g_next
      assign r_in = rs[k-1];
      assign q_in = qs[k-1];
      assign x_in = xs[k-1];
    end

    always_comb begin
      t   = {r_in, x_in[SW-1 -: 2]};
      sub = {2'b00, q_in, 2'b01};
      ge  = t >= sub;
    end

    always_ff @(posedge clk) begin
      rs[k] <= ge ? RW'(t - sub) : RW'(t);
      qs[k] <= {q_in[N-2:0], ge};
      xs[k] <= x_in << 2;
    end
  end

  assign root = qs[N-1];

endmodule

// File: src/rcva_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rcva_div #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 31,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int RW = DEN_W + 1;

  logic [RW-1:0]    rs [Q_W];
  logic [Q_W-1:0]   xs [Q_W];
  logic [Q_W-1:0]   qs [Q_W];
  logic [DEN_W-1:0] ds [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [RW-1:0]    r_in;
    logic [Q_W-1:0]   x_in;
    logic [Q_W-1:0]   q_in;
    logic [DEN_W-1:0] d_in;
    logic [RW-1:0]    t;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in = RW'(num[NUM_W-1:Q_W]);
      assign x_in = num[Q_W-1:0];
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign r_in = rs[k-1];
      assign x_in = xs[k-1];
      assign q_in = qs[k-1];
      assign d_in = ds[k-1];
    end

    always_comb begin
      t  = {r_in[RW-2:0], x_in[Q_W-1]};
      ge = t >= {1'b0, d_in};
    end

    always_ff @(posedge clk) begin
      rs[k] <= ge ? t - {1'b0, d_in} : t;
      xs[k] <= x_in << 1;
      qs[k] <= {q_in[Q_W-2:0], ge};
      ds[k] <= d_in;
    end
  end

  assign quo = qs[Q_W-1];

endmodule
